// File: rtl/rpb_pkg.sv
// Shared types and constants for the RGB pixel blend unit.
`default_nettype none

package rpb_pkg;

    // Mode codes carried by each item.
    typedef enum logic [2:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SUBTRACT = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_OVERLAY  = 3'd3,
        MODE_ADD      = 3'd4,
        MODE_SCALE    = 3'd5
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_OPERAND_RED   = 2'd0,
        REG_OPERAND_GREEN = 2'd1,
        REG_OPERAND_BLUE  = 2'd2
    } t_reg_index;

    // How the last stage forms a channel from the pipeline values.
    typedef enum logic [1:0] {
        KIND_DIV    = 2'd0,  // quotient of the product by 255
        KIND_INV    = 2'd1,  // 255 minus that quotient
        KIND_CLAMP  = 2'd2,  // product saturated at 255
        KIND_DIRECT = 2'd3   // value settled in the first stage
    } t_kind;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned PROD_W    = 2 * CH_W;
    localparam int unsigned OPND_W    = 9;
    localparam int unsigned RECIP_W   = 17;
    localparam int unsigned RECIP_SH  = 24;
    localparam int unsigned LATENCY   = 4;

    // ceil(2^24 / 255): exact floor division by 255 for any 16-bit product.
    localparam logic [RECIP_W-1:0] RECIP_255 = 17'd65794;
    localparam logic [CH_W-1:0]    CH_MAX    = 8'd255;

    // Per-channel operands handed from the decode stage to the arithmetic stages.
    typedef struct packed {
        logic [CH_W-1:0] x;
        logic [CH_W-1:0] y;
        logic            gain;
        t_kind           kind;
        logic [CH_W-1:0] direct;
    } t_prep;

endpackage

`default_nettype wire

// File: rtl/rpb_prep.sv
// Mode decode for one channel: picks multiplier operands or a direct result.
`default_nettype none

module rpb_prep (
    input  wire logic [2:0]                 i_mode,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_base,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_blend,
    input  wire logic [rpb_pkg::OPND_W-1:0] i_operand,
    output rpb_pkg::t_prep                  o_prep
);

    logic signed [rpb_pkg::OPND_W:0] n_sum;
    logic [rpb_pkg::CH_W-1:0]        n_add_res;
    logic [rpb_pkg::CH_W-1:0]        n_sub_res;

    // Offset mode: the sum spans -256..510, so ten signed bits hold it.
    assign n_sum = $signed({2'b00, i_base}) + $signed({i_operand[rpb_pkg::OPND_W-1], i_operand});

    always_comb begin
        if (n_sum[rpb_pkg::OPND_W]) begin
            n_add_res = '0;
        end else if (n_sum[rpb_pkg::OPND_W-1]) begin
            n_add_res = rpb_pkg::CH_MAX;
        end else begin
            n_add_res = n_sum[rpb_pkg::CH_W-1:0];
        end
    end

    assign n_sub_res = (i_base > i_blend) ? (i_base - i_blend) : '0;

    // Operand selection. 255-v is the bitwise complement of an 8-bit value.
    always_comb begin
        o_prep.x      = i_base;
        o_prep.y      = i_blend;
        o_prep.gain   = 1'b0;
        o_prep.kind   = rpb_pkg::KIND_DIRECT;
        o_prep.direct = i_base;
        unique case (rpb_pkg::t_mode'(i_mode))
            rpb_pkg::MODE_MULTIPLY: begin
                o_prep.kind = rpb_pkg::KIND_DIV;
            end
            rpb_pkg::MODE_SUBTRACT: begin
                o_prep.direct = n_sub_res;
            end
            rpb_pkg::MODE_SCREEN: begin
                o_prep.x    = ~i_base;
                o_prep.y    = ~i_blend;
                o_prep.kind = rpb_pkg::KIND_INV;
            end
            rpb_pkg::MODE_OVERLAY: begin
                o_prep.gain = 1'b1;
                if (i_blend[rpb_pkg::CH_W-1]) begin
                    o_prep.x    = ~i_base;
                    o_prep.y    = ~i_blend;
                    o_prep.kind = rpb_pkg::KIND_INV;
                end else begin
                    o_prep.kind = rpb_pkg::KIND_DIV;
                end
            end
            rpb_pkg::MODE_ADD: begin
                o_prep.direct = n_add_res;
            end
            rpb_pkg::MODE_SCALE: begin
                // A negative factor always clamps to zero.
                if (i_operand[rpb_pkg::OPND_W-1]) begin
                    o_prep.direct = '0;
                end else begin
                    o_prep.y    = i_operand[rpb_pkg::CH_W-1:0];
                    o_prep.kind = rpb_pkg::KIND_CLAMP;
                end
            end
            default: begin
                // Unused codes pass the base channel through.
                o_prep.direct = i_base;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rpb_arith.sv
// Three arithmetic stages for one channel: multiply, divide by 255, final select.
`default_nettype none

module rpb_arith (
    input  wire logic                     i_clk,
    input  rpb_pkg::t_prep                i_prep,
    output logic [rpb_pkg::CH_W-1:0]      o_res
);

    rpb_pkg::t_prep                        r_b_prep;
    logic [rpb_pkg::PROD_W-1:0]            r_c_p;
    rpb_pkg::t_kind                        r_c_kind;
    logic [rpb_pkg::CH_W-1:0]              r_c_direct;
    logic [rpb_pkg::CH_W-1:0]              r_d_q;
    logic                                  r_d_sat;
    logic [rpb_pkg::CH_W-1:0]              r_d_plow;
    rpb_pkg::t_kind                        r_d_kind;
    logic [rpb_pkg::CH_W-1:0]              r_d_direct;

    logic [rpb_pkg::PROD_W-1:0]                   n_mul;
    logic [rpb_pkg::PROD_W-1:0]                   n_p;
    logic [rpb_pkg::PROD_W+rpb_pkg::RECIP_W-1:0]  n_prod;

    // Stage B: 8x8 product, doubled in overlay mode. The doubled product
    // only occurs with y at most 127, so it stays within 16 bits.
    assign n_mul = {{rpb_pkg::CH_W{1'b0}}, r_b_prep.x}
                 * {{rpb_pkg::CH_W{1'b0}}, r_b_prep.y};
    assign n_p   = r_b_prep.gain ? {n_mul[rpb_pkg::PROD_W-2:0], 1'b0} : n_mul;

    // Stage C: divide by 255 through the reciprocal multiply.
    assign n_prod = {{rpb_pkg::RECIP_W{1'b0}}, r_c_p}
                  * {{rpb_pkg::PROD_W{1'b0}}, rpb_pkg::RECIP_255};

    // Pipeline registers; the stream never stalls, so they load every cycle.
    always_ff @(posedge i_clk) begin
        r_b_prep   <= i_prep;
        r_c_p      <= n_p;
        r_c_kind   <= r_b_prep.kind;
        r_c_direct <= r_b_prep.direct;
        r_d_q      <= n_prod[rpb_pkg::RECIP_SH +: rpb_pkg::CH_W];
        r_d_sat    <= |r_c_p[rpb_pkg::PROD_W-1:rpb_pkg::CH_W];
        r_d_plow   <= r_c_p[rpb_pkg::CH_W-1:0];
        r_d_kind   <= r_c_kind;
        r_d_direct <= r_c_direct;
    end

    // Stage D: form the channel result.
    always_comb begin
        case (r_d_kind)
            rpb_pkg::KIND_DIV:   o_res = r_d_q;
            rpb_pkg::KIND_INV:   o_res = rpb_pkg::CH_MAX - r_d_q;
            rpb_pkg::KIND_CLAMP: o_res = r_d_sat ? rpb_pkg::CH_MAX : r_d_plow;
            default:             o_res = r_d_direct;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rgb_pixel_blend_unit.sv
// Top level of the RGB pixel blend unit: ports, operand registers, valid pipeline.
//
//  Channel   | Handshake                    | Payload
//  ----------+------------------------------+-------------------------------------
//  item in   | i_start / o_busy             | i_mode, i_base_*, i_blend_*
//  result    | o_valid (one-cycle strobe)   | o_out_red, o_out_green, o_out_blue
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item is taken in every cycle; o_busy stays low.
// Each result passes, after its transfer, through the decode register, the multiply,
// the divide by 255 through a reciprocal multiply, then the output register.
// Reset (synchronous, active low) clears the valid pipeline and sets all three
// operand registers to zero. The receiver cannot stall, so no stage ever holds.
`default_nettype none

module rgb_pixel_blend_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [2:0]                 i_mode,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_base_red,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_base_green,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_base_blue,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_blend_red,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_blend_green,
    input  wire logic [rpb_pkg::CH_W-1:0]   i_blend_blue,
    output logic                            o_valid,
    output logic [rpb_pkg::CH_W-1:0]        o_out_red,
    output logic [rpb_pkg::CH_W-1:0]        o_out_green,
    output logic [rpb_pkg::CH_W-1:0]        o_out_blue,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [rpb_pkg::OPND_W-1:0] i_cfg_data
);

    logic [rpb_pkg::OPND_W-1:0] r_operand_red;
    logic [rpb_pkg::OPND_W-1:0] r_operand_green;
    logic [rpb_pkg::OPND_W-1:0] r_operand_blue;
    logic [rpb_pkg::LATENCY-1:0] r_vld;
    logic [rpb_pkg::CH_W-1:0]   r_out_red;
    logic [rpb_pkg::CH_W-1:0]   r_out_green;
    logic [rpb_pkg::CH_W-1:0]   r_out_blue;

    logic                       n_accept;
    rpb_pkg::t_prep             n_prep_red;
    rpb_pkg::t_prep             n_prep_green;
    rpb_pkg::t_prep             n_prep_blue;
    logic [rpb_pkg::CH_W-1:0]   n_res_red;
    logic [rpb_pkg::CH_W-1:0]   n_res_green;
    logic [rpb_pkg::CH_W-1:0]   n_res_blue;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = i_start && !o_busy;

    // Operand register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operand_red   <= '0;
            r_operand_green <= '0;
            r_operand_blue  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rpb_pkg::t_reg_index'(i_cfg_index))
                rpb_pkg::REG_OPERAND_RED:   r_operand_red   <= i_cfg_data;
                rpb_pkg::REG_OPERAND_GREEN: r_operand_green <= i_cfg_data;
                rpb_pkg::REG_OPERAND_BLUE:  r_operand_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-channel decode.
    rpb_prep u_prep_red (
        .i_mode    (i_mode),
        .i_base    (i_base_red),
        .i_blend   (i_blend_red),
        .i_operand (r_operand_red),
        .o_prep    (n_prep_red)
    );

    rpb_prep u_prep_green (
        .i_mode    (i_mode),
        .i_base    (i_base_green),
        .i_blend   (i_blend_green),
        .i_operand (r_operand_green),
        .o_prep    (n_prep_green)
    );

    rpb_prep u_prep_blue (
        .i_mode    (i_mode),
        .i_base    (i_base_blue),
        .i_blend   (i_blend_blue),
        .i_operand (r_operand_blue),
        .o_prep    (n_prep_blue)
    );

    // Per-channel arithmetic pipelines.
    rpb_arith u_arith_red (
        .i_clk  (i_clk),
        .i_prep (n_prep_red),
        .o_res  (n_res_red)
    );

    rpb_arith u_arith_green (
        .i_clk  (i_clk),
        .i_prep (n_prep_green),
        .o_res  (n_res_green)
    );

    rpb_arith u_arith_blue (
        .i_clk  (i_clk),
        .i_prep (n_prep_blue),
        .o_res  (n_res_blue)
    );

    // Valid bits travel alongside the data, one per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[rpb_pkg::LATENCY-2:0], n_accept};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_out_red   <= n_res_red;
        r_out_green <= n_res_green;
        r_out_blue  <= n_res_blue;
    end

    assign o_valid     = r_vld[rpb_pkg::LATENCY-1];
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

`ifndef SYNTHESIS
    // Every result strobe goes back to a transfer that has passed the whole valid pipeline.
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 4))
        else $error("result strobe without a matching input transfer");

    // Unused mode codes return the base pixel unchanged; red and blue are checked.
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && (i_mode[2:1] == 2'b11)) |-> ##4
        (o_valid && (o_out_red == $past(i_base_red, 4))
                 && (o_out_blue == $past(i_base_blue, 4))))
        else $error("unused mode did not pass the base pixel through");

    // Multiplying by full white leaves the base channel as it was.
    a_multiply_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && (i_mode == rpb_pkg::MODE_MULTIPLY) && (i_blend_green == rpb_pkg::CH_MAX))
        |-> ##4 (o_out_green == $past(i_base_green, 4)))
        else $error("multiply by 255 changed the base channel");
`endif

endmodule

`default_nettype wire
